/* rtl/core/pdh_pkg.sv */
// ----------------------------------------------------------------------------
// pdh_pkg
// Shared constants, types and build-time cell ROMs of the polar density
// histogram smoother.
// ----------------------------------------------------------------------------
`default_nettype none

package pdh_pkg;

  localparam int SECTORS     = 72;
  localparam int WINDOW      = 16;
  localparam int HALF_WIN    = WINDOW / 2;
  localparam int ROM_DEPTH   = WINDOW * WINDOW;
  localparam int OCT_SECTORS = SECTORS / 8;

  localparam int KIND_W     = 2;
  localparam int BIN_W      = 7;
  localparam int CELL_W     = 4;
  localparam int COUNT_W    = 8;
  localparam int COEF_W     = 16;
  localparam int SPAN_W     = 5;
  localparam int DENS_W     = 48;
  localparam int DIST_W     = 16;
  localparam int CSQ_W      = 2 * COUNT_W;
  localparam int BD_W       = COEF_W + DIST_W;
  localparam int FACTOR_W   = BD_W + 1;
  localparam int ADDPROD_W  = CSQ_W + 1 + FACTOR_W;
  localparam int CONTRIB_W  = ADDPROD_W - 8;
  localparam int WPROD_W    = DENS_W + SPAN_W + 1;
  localparam int ACC_W      = DENS_W + 2 * SPAN_W;
  localparam int DIVISOR_W  = SPAN_W + 1;
  localparam int RDCNT_W    = SPAN_W + 1;
  localparam int STEP_W     = $clog2(ACC_W);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  localparam logic [COEF_W-1:0] OFFSET_RST = 16'd256;
  localparam logic [COEF_W-1:0] SLOPE_RST  = 16'd0;
  localparam logic [SPAN_W-1:0] SPAN_RST   = 5'd5;

  localparam logic [DENS_W-1:0] DENS_MAX = {1'b0, {(DENS_W-1){1'b1}}};
  localparam logic [DENS_W-1:0] DENS_MIN = {1'b1, {(DENS_W-1){1'b0}}};

  typedef enum logic [KIND_W-1:0] {
    KIND_CLEAR = 2'd0,
    KIND_ADD   = 2'd1,
    KIND_QUERY = 2'd2
  } kind_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DENSITY_OFFSET = 2'd0,
    CFG_DISTANCE_SLOPE = 2'd1,
    CFG_SMOOTH_SPAN    = 2'd2
  } cfg_idx_t;

  typedef struct packed {
    logic                     clr;
    logic                     rd_en;
    logic [BIN_W-1:0]         rd_addr;
    logic                     wr_en;
    logic [BIN_W-1:0]         wr_addr;
    logic [DENS_W-1:0]        wr_data;
  } mem_req_t;

  // tan of the sector edges inside the first octant, q16
  localparam longint TAN_Q16 [OCT_SECTORS-1] = '{
    5734, 11556, 17560, 23853, 30560, 37837, 45889, 54991
  };

  typedef logic [BIN_W-1:0]  bin_rom_t  [ROM_DEPTH];
  typedef logic [DIST_W-1:0] dist_rom_t [ROM_DEPTH];

  function automatic int bin_of(int dx, int dy);
    int ax;
    int ay;
    int lo;
    int hi;
    int j;
    int s0;
    ax = (dx < 0) ? -dx : dx;
    ay = (dy < 0) ? -dy : dy;
    if (dx == 0 && dy == 0) return 0;
    if (dy == 0) return (dx > 0) ? 0 : SECTORS / 2;
    if (dx == 0) return (dy > 0) ? SECTORS / 4 : 3 * SECTORS / 4;
    if (ax == ay) begin
      if (dx > 0) return (dy > 0) ? OCT_SECTORS : 7 * OCT_SECTORS;
      return (dy > 0) ? 3 * OCT_SECTORS : 5 * OCT_SECTORS;
    end
    lo = (ax < ay) ? ax : ay;
    hi = (ax < ay) ? ay : ax;
    j  = 0;
    for (int k = 0; k < OCT_SECTORS - 1; k++) begin
      if (longint'(lo) * 65536 > longint'(hi) * TAN_Q16[k]) j++;
    end
    s0 = (ay < ax) ? j : 2 * OCT_SECTORS - 1 - j;
    if (dx > 0 && dy > 0) return s0;
    if (dx < 0 && dy > 0) return SECTORS / 2 - 1 - s0;
    if (dx < 0) return SECTORS / 2 + s0;
    return SECTORS - 1 - s0;
  endfunction

  // sqrt(n) in q8.8, rounded to nearest
  function automatic longint dist_of(int n);
    longint orig;
    longint x;
    longint res;
    longint b;
    orig = longint'(n) << 16;
    x    = orig;
    res  = 0;
    b    = longint'(1) << 30;
    for (int i = 0; i < 16; i++) begin
      if (x >= res + b) begin
        x   = x - (res + b);
        res = (res >> 1) + b;
      end else begin
        res = res >> 1;
      end
      b = b >> 2;
    end
    if (orig > res * res + res) res = res + 1;
    return res;
  endfunction

  function automatic bin_rom_t bin_rom_init();
    bin_rom_t rom;
    for (int r = 0; r < WINDOW; r++) begin
      for (int c = 0; c < WINDOW; c++) begin
        rom[r * WINDOW + c] = BIN_W'(bin_of(r - HALF_WIN, c - HALF_WIN));
      end
    end
    return rom;
  endfunction

  function automatic dist_rom_t dist_rom_init();
    dist_rom_t rom;
    int dx;
    int dy;
    for (int r = 0; r < WINDOW; r++) begin
      for (int c = 0; c < WINDOW; c++) begin
        dx = r - HALF_WIN;
        dy = c - HALF_WIN;
        rom[r * WINDOW + c] = DIST_W'(dist_of(dx * dx + dy * dy));
      end
    end
    return rom;
  endfunction

  localparam bin_rom_t  BIN_ROM  = bin_rom_init();
  localparam dist_rom_t DIST_ROM = dist_rom_init();

endpackage

`default_nettype wire

/* rtl/core/pdh_in_if.sv */
// ----------------------------------------------------------------------------
// pdh_in_if
// Input item channel: clear, add cell or query sector.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdh_in_if;
  logic                         valid;
  logic                         ready;
  logic [pdh_pkg::KIND_W-1:0]   kind;
  logic [pdh_pkg::CELL_W-1:0]   cell_row;
  logic [pdh_pkg::CELL_W-1:0]   cell_col;
  logic [pdh_pkg::COUNT_W-1:0]  cell_count;
  logic [pdh_pkg::BIN_W-1:0]    query_sector;

  modport source (output valid, kind, cell_row, cell_col, cell_count, query_sector,
                  input ready);
  modport sink   (input valid, kind, cell_row, cell_col, cell_count, query_sector,
                  output ready);
endinterface

`default_nettype wire

/* rtl/core/pdh_out_if.sv */
// ----------------------------------------------------------------------------
// pdh_out_if
// Result item channel: queried sector and its smoothed density.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdh_out_if;
  logic                               valid;
  logic                               ready;
  logic [pdh_pkg::BIN_W-1:0]          sector_index;
  logic signed [pdh_pkg::DENS_W-1:0]  smoothed_density;

  modport source (output valid, sector_index, smoothed_density, input ready);
  modport sink   (input valid, sector_index, smoothed_density, output ready);
endinterface

`default_nettype wire

/* rtl/core/pdh_cfg_if.sv */
// ----------------------------------------------------------------------------
// pdh_cfg_if
// Configuration register write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface pdh_cfg_if;
  logic                              valid;
  logic                              ready;
  logic [pdh_pkg::CFG_IDX_W-1:0]     index;
  logic [pdh_pkg::CFG_DATA_W-1:0]    data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

/* rtl/core/polar_density_histogram_smoother.sv */
// ----------------------------------------------------------------------------
// polar_density_histogram_smoother
// Clear: empties every bin. Add: a read-modify-write of one bin in the
// sector memory. Query: a sweep of the bins round the queried sector (one
// memory read per cycle), then the 58-step divider. One item at a time.
// Reset clears all bins, loads register defaults and empties the output.
// ----------------------------------------------------------------------------
`default_nettype none

module polar_density_histogram_smoother (
  input  logic       clk,
  input  logic       rst_n,
  pdh_in_if.sink     in_ch,
  pdh_out_if.source  out_ch,
  pdh_cfg_if.sink    cfg_ch
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_ADD_LOOK,
    S_ADD_MUL,
    S_ADD_WR,
    S_Q_SWEEP,
    S_Q_DRAIN,
    S_Q_DIV,
    S_Q_OUT
  } state_t;

  state_t state_r;
  state_t state_nxt;

  logic [pdh_pkg::COEF_W-1:0] offset_r;
  logic [pdh_pkg::COEF_W-1:0] slope_r;
  logic [pdh_pkg::SPAN_W-1:0] span_r;

  logic [pdh_pkg::CELL_W-1:0]          row_r;
  logic [pdh_pkg::CELL_W-1:0]          col_r;
  logic [pdh_pkg::COUNT_W-1:0]         count_r;
  logic [pdh_pkg::BIN_W-1:0]           bin_r;
  logic [pdh_pkg::BD_W-1:0]            bd_r;
  logic [pdh_pkg::CSQ_W-1:0]           csq_r;
  logic signed [pdh_pkg::ADDPROD_W-1:0] addprod_r;

  logic [pdh_pkg::BIN_W-1:0]           qsec_r;
  logic [pdh_pkg::BIN_W-1:0]           rd_idx_r;
  logic [pdh_pkg::RDCNT_W-1:0]         rd_cnt_r;
  logic [pdh_pkg::SPAN_W-1:0]          wt_r;
  logic                                up_r;
  logic                                rv1_r;
  logic [pdh_pkg::SPAN_W-1:0]          wt1_r;
  logic                                pv_r;
  logic signed [pdh_pkg::WPROD_W-1:0]  wprod_r;
  logic signed [pdh_pkg::ACC_W-1:0]    acc_r;

  logic                                out_vld_r;
  logic [pdh_pkg::BIN_W-1:0]           out_sec_r;
  logic signed [pdh_pkg::DENS_W-1:0]   out_dens_r;

  logic                                in_acc;
  logic                                cfg_acc;
  logic [$clog2(pdh_pkg::ROM_DEPTH)-1:0] rom_addr;
  logic [pdh_pkg::BIN_W-1:0]           rom_bin;
  logic [pdh_pkg::DIST_W-1:0]          rom_dist;
  logic signed [pdh_pkg::FACTOR_W-1:0] factor;
  logic signed [pdh_pkg::ADDPROD_W-1:0] rounded;
  logic signed [pdh_pkg::CONTRIB_W-1:0] contrib;
  logic signed [pdh_pkg::DENS_W:0]     sum_w;
  logic [pdh_pkg::DENS_W-1:0]          sat_sum;
  logic [pdh_pkg::BIN_W:0]             start_raw;
  logic [pdh_pkg::BIN_W:0]             start_idx;
  logic                                q_ok;
  logic                                div_start;
  logic                                div_done;
  logic signed [pdh_pkg::DENS_W-1:0]   div_q;
  logic                                out_free;
  pdh_pkg::mem_req_t                   mem_req;
  logic signed [pdh_pkg::DENS_W-1:0]   mem_rd;

  assign in_acc     = in_ch.valid && in_ch.ready;
  assign cfg_acc    = cfg_ch.valid && cfg_ch.ready;
  assign in_ch.ready  = state_r == S_IDLE;
  assign cfg_ch.ready = 1'b1;
  assign out_free   = !out_vld_r || out_ch.ready;

  assign out_ch.valid            = out_vld_r;
  assign out_ch.sector_index     = out_sec_r;
  assign out_ch.smoothed_density = out_dens_r;

  // cell lookup
  always_comb begin
    rom_addr = {row_r, col_r};
    rom_bin  = pdh_pkg::BIN_ROM[rom_addr];
    rom_dist = pdh_pkg::DIST_ROM[rom_addr];
  end

  // density update arithmetic
  always_comb begin
    factor  = $signed({1'b0, offset_r, 8'b0}) - $signed({1'b0, bd_r});
    rounded = addprod_r + $signed({{(pdh_pkg::ADDPROD_W-8){1'b0}},
                                   {8{addprod_r[pdh_pkg::ADDPROD_W-1]}}});
    contrib = rounded[pdh_pkg::ADDPROD_W-1:8];
    sum_w   = (pdh_pkg::DENS_W+1)'(mem_rd) + (pdh_pkg::DENS_W+1)'(contrib);
    if (sum_w[pdh_pkg::DENS_W] != sum_w[pdh_pkg::DENS_W-1]) begin
      sat_sum = sum_w[pdh_pkg::DENS_W] ? pdh_pkg::DENS_MIN : pdh_pkg::DENS_MAX;
    end else begin
      sat_sum = sum_w[pdh_pkg::DENS_W-1:0];
    end
  end

  // first bin of the query sweep, wrapped round the circle
  always_comb begin
    start_raw = {1'b0, in_ch.query_sector} + (pdh_pkg::BIN_W+1)'(1)
              - {3'b0, span_r};
    start_idx = start_raw[pdh_pkg::BIN_W]
              ? start_raw + (pdh_pkg::BIN_W+1)'(pdh_pkg::SECTORS) : start_raw;
    q_ok      = in_ch.query_sector < pdh_pkg::BIN_W'(pdh_pkg::SECTORS);
  end

  always_comb begin
    mem_req.clr     = in_acc && (in_ch.kind == pdh_pkg::KIND_CLEAR);
    mem_req.rd_en   = (state_r == S_ADD_LOOK) || (state_r == S_Q_SWEEP);
    mem_req.rd_addr = (state_r == S_ADD_LOOK) ? rom_bin : rd_idx_r;
    mem_req.wr_en   = state_r == S_ADD_WR;
    mem_req.wr_addr = bin_r;
    mem_req.wr_data = sat_sum;
  end

  assign div_start = (state_r == S_Q_DRAIN) && !rv1_r && !pv_r;

  pdh_bin_mem u_mem (
    .clk     (clk),
    .rst_n   (rst_n),
    .req     (mem_req),
    .rd_data (mem_rd)
  );

  pdh_divider u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (acc_r),
    .divisor  ({span_r, 1'b1}),
    .done     (div_done),
    .quotient (div_q)
  );

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_acc) begin
          case (in_ch.kind)
            pdh_pkg::KIND_ADD: state_nxt = S_ADD_LOOK;
            pdh_pkg::KIND_QUERY: begin
              if (q_ok) state_nxt = (span_r == '0) ? S_Q_DRAIN : S_Q_SWEEP;
            end
            default: state_nxt = S_IDLE;
          endcase
        end
      end
      S_ADD_LOOK: state_nxt = S_ADD_MUL;
      S_ADD_MUL:  state_nxt = S_ADD_WR;
      S_ADD_WR:   state_nxt = S_IDLE;
      S_Q_SWEEP: begin
        if (rd_cnt_r == pdh_pkg::RDCNT_W'(1)) state_nxt = S_Q_DRAIN;
      end
      S_Q_DRAIN: begin
        if (div_start) state_nxt = S_Q_DIV;
      end
      S_Q_DIV: begin
        if (div_done) state_nxt = S_Q_OUT;
      end
      S_Q_OUT: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_Q_OUT && out_free) begin
        out_vld_r  <= 1'b1;
        out_sec_r  <= qsec_r;
        out_dens_r <= div_q;
      end else if (out_ch.ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      offset_r <= pdh_pkg::OFFSET_RST;
      slope_r  <= pdh_pkg::SLOPE_RST;
      span_r   <= pdh_pkg::SPAN_RST;
    end else if (cfg_acc) begin
      case (cfg_ch.index)
        pdh_pkg::CFG_DENSITY_OFFSET: offset_r <= cfg_ch.data;
        pdh_pkg::CFG_DISTANCE_SLOPE: slope_r  <= cfg_ch.data;
        pdh_pkg::CFG_SMOOTH_SPAN:    span_r   <= cfg_ch.data[pdh_pkg::SPAN_W-1:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rv1_r <= 1'b0;
      pv_r  <= 1'b0;
    end else begin
      rv1_r <= state_r == S_Q_SWEEP;
      pv_r  <= rv1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      row_r    <= in_ch.cell_row;
      col_r    <= in_ch.cell_col;
      count_r  <= in_ch.cell_count;
      qsec_r   <= in_ch.query_sector;
      rd_idx_r <= start_idx[pdh_pkg::BIN_W-1:0];
      rd_cnt_r <= {span_r, 1'b0} - 1'b1;
      wt_r     <= pdh_pkg::SPAN_W'(1);
      up_r     <= 1'b1;
      acc_r    <= '0;
    end
    if (state_r == S_ADD_LOOK) begin
      bin_r <= rom_bin;
      bd_r  <= slope_r * rom_dist;
      csq_r <= count_r * count_r;
    end
    if (state_r == S_ADD_MUL) begin
      addprod_r <= $signed({1'b0, csq_r}) * factor;
    end
    if (state_r == S_Q_SWEEP) begin
      rd_idx_r <= (rd_idx_r == pdh_pkg::BIN_W'(pdh_pkg::SECTORS - 1))
                ? '0 : rd_idx_r + 1'b1;
      rd_cnt_r <= rd_cnt_r - 1'b1;
      wt1_r    <= wt_r;
      // triangular weight: 1 up to span, then back down
      if (up_r && wt_r == span_r) begin
        up_r <= 1'b0;
        wt_r <= wt_r - 1'b1;
      end else begin
        wt_r <= up_r ? wt_r + 1'b1 : wt_r - 1'b1;
      end
    end
    if (rv1_r) begin
      wprod_r <= mem_rd * $signed({1'b0, wt1_r});
    end
    if (pv_r) begin
      acc_r <= acc_r + pdh_pkg::ACC_W'(wprod_r);
    end
  end

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> state_r == S_Q_DIV)
    else $error("divider finished outside the wait state");

  a_write_after_mul: assert property (@(posedge clk) disable iff (!rst_n)
    mem_req.wr_en |-> $past(state_r) == S_ADD_MUL)
    else $error("bin written without its read and multiply");

  a_sweep_drained: assert property (@(posedge clk) disable iff (!rst_n)
    state_r == S_IDLE |-> !rv1_r && !pv_r)
    else $error("sweep pipeline busy while idle");

  a_out_from_query: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_vld_r) |-> $past(state_r) == S_Q_OUT)
    else $error("result item raised outside a query");

endmodule

`default_nettype wire

/* rtl/core/pdh_bin_mem.sv */
// ----------------------------------------------------------------------------
// pdh_bin_mem
// Sector density memory, one read and one write port, registered read,
// with per-entry valid bits so that a clear only resets the valid bits.
// ----------------------------------------------------------------------------
`default_nettype none

module pdh_bin_mem (
  input  logic                              clk,
  input  logic                              rst_n,
  input  pdh_pkg::mem_req_t                 req,
  output logic signed [pdh_pkg::DENS_W-1:0] rd_data
);

  logic [pdh_pkg::DENS_W-1:0]  mem_r [pdh_pkg::SECTORS];
  logic [pdh_pkg::SECTORS-1:0] vld_r;
  logic [pdh_pkg::DENS_W-1:0]  data_r;
  logic                        hit_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (req.clr) begin
      vld_r <= '0;
    end else if (req.wr_en) begin
      vld_r[req.wr_addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem_r[req.wr_addr] <= req.wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (req.rd_en) begin
      data_r <= mem_r[req.rd_addr];
      hit_r  <= vld_r[req.rd_addr];
    end
  end

  // entries not written since the last clear read as zero
  assign rd_data = hit_r ? $signed(data_r) : '0;

endmodule

`default_nettype wire

/* rtl/core/pdh_divider.sv */
// ----------------------------------------------------------------------------
// pdh_divider
// Signed by unsigned restoring divider, one quotient bit per cycle,
// truncating toward zero and saturating to the density range.
// ----------------------------------------------------------------------------
`default_nettype none

module pdh_divider (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  input  logic signed [pdh_pkg::ACC_W-1:0]    dividend,
  input  logic [pdh_pkg::DIVISOR_W-1:0]       divisor,
  output logic                                done,
  output logic signed [pdh_pkg::DENS_W-1:0]   quotient
);

  localparam int AW = pdh_pkg::ACC_W;
  localparam int DW = pdh_pkg::DENS_W;
  localparam int VW = pdh_pkg::DIVISOR_W;

  logic [AW-1:0]               quo_r;
  logic [VW-1:0]               rem_r;
  logic [VW-1:0]               dvs_r;
  logic                        neg_r;
  logic [pdh_pkg::STEP_W-1:0]  step_r;
  logic                        run_r;
  logic                        fin_r;
  logic                        done_r;
  logic [DW-1:0]               res_r;

  logic [VW:0] rem_sh;
  logic [VW:0] rem_sub;
  logic        ge;
  logic        over;

  always_comb begin
    rem_sh  = {rem_r, quo_r[AW-1]};
    ge      = rem_sh >= {1'b0, dvs_r};
    rem_sub = rem_sh - {1'b0, dvs_r};
    if (neg_r) begin
      over = (|quo_r[AW-1:DW]) || (quo_r[DW-1] && (|quo_r[DW-2:0]));
    end else begin
      over = |quo_r[AW-1:DW-1];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      fin_r  <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r  <= 1'b1;
        step_r <= pdh_pkg::STEP_W'(AW - 1);
        quo_r  <= dividend[AW-1] ? AW'(-dividend) : AW'(dividend);
        rem_r  <= '0;
        dvs_r  <= divisor;
        neg_r  <= dividend[AW-1];
      end else if (run_r) begin
        quo_r <= {quo_r[AW-2:0], ge};
        rem_r <= ge ? rem_sub[VW-1:0] : rem_sh[VW-1:0];
        if (step_r == '0) begin
          run_r <= 1'b0;
          fin_r <= 1'b1;
        end else begin
          step_r <= step_r - 1'b1;
        end
      end else if (fin_r) begin
        fin_r  <= 1'b0;
        done_r <= 1'b1;
        if (over) begin
          res_r <= neg_r ? pdh_pkg::DENS_MIN : pdh_pkg::DENS_MAX;
        end else begin
          res_r <= neg_r ? -quo_r[DW-1:0] : quo_r[DW-1:0];
        end
      end
    end
  end

  assign done     = done_r;
  assign quotient = $signed(res_r);

endmodule

`default_nettype wire
